FILE: sv/wbum_pkg.sv
package wbum_pkg;

  // Ring geometry.
  localparam int BUCKET_SLOTS = 16;
  localparam int SLOT_W       = $clog2(BUCKET_SLOTS);
  localparam int CNT_W        = $clog2(BUCKET_SLOTS + 1);

  // Field widths.
  localparam int TIME_W = 63;
  localparam int REG_W  = 40;
  localparam int UTIL_W = 15;

  // 100.0 percent in unsigned Q7.8.
  localparam logic [UTIL_W-1:0] FULL_SCALE = 15'd25600;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b1;
  localparam logic [REG_W-1:0] BUCKET_LENGTH_RESET = 40'd1000000000;
  localparam logic [REG_W-1:0] WINDOW_LENGTH_RESET = 40'd10000000000;

  // One time bucket as held by a cell.
  typedef struct packed {
    logic [TIME_W-1:0] end_ns;
    logic [TIME_W-1:0] sum_ns;
    logic [TIME_W-1:0] act_ns;
  } bucket_t;

  // What a cell does at the next clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_UP,
    CELL_DOWN,
    CELL_WRITE
  } cell_op_t;

  // Sum of two non-negative 63-bit values, clipped at the largest value.
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                               input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

endpackage

FILE: sv/windowed_busy_utilization_meter_top.sv
// Channel   Direction  Handshake               Payload
// request   in         in_valid / in_ready     timestamp_ns, busy_now
// result    out        out_valid / out_ready   utilization_q7_8, busy_time_total_ns,
//                                              busy_state, became_busy, became_idle
// config    in         cfg_write               cfg_index, cfg_data
//
// One request is worked on at a time. With 16 bucket cells, its work runs through
// a step per bucket that expires (0 to 15 of them), a summing pass, one cell a
// cycle around the chain, and a serial divider that is skipped when the ring
// holds no time at all; the divider takes a shift step and an add step per bit
// of the 15-bit quotient. The next request can be taken in the cycle after the
// result reaches the output register. A new request is taken while a finished
// result still waits in the output register; if a second result finishes before
// the first is taken, the input stays closed until the output register frees.
// Reset is synchronous and clears the control state and the configuration
// registers to their defaults; bucket contents need no reset.
module windowed_busy_utilization_meter_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [wbum_pkg::TIME_W-1:0]          timestamp_ns,
  input  logic                                 busy_now,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [wbum_pkg::UTIL_W-1:0]          utilization_q7_8,
  output logic [wbum_pkg::TIME_W-1:0]          busy_time_total_ns,
  output logic                                 busy_state,
  output logic                                 became_busy,
  output logic                                 became_idle,
  input  logic                                 cfg_write,
  input  logic [wbum_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wbum_pkg::REG_W-1:0]           cfg_data
);

  localparam int SLOTS  = wbum_pkg::BUCKET_SLOTS;
  localparam int SLOT_W = wbum_pkg::SLOT_W;
  localparam int CNT_W  = wbum_pkg::CNT_W;
  localparam int TW     = wbum_pkg::TIME_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_YOUNG,
    S_UPD,
    S_EXP,
    S_SUM,
    S_CHK,
    S_DIV
  } state_t;

  state_t state;
  logic   result_wait;

  // Configuration registers.
  logic [wbum_pkg::REG_W-1:0] bucket_length_ns;
  logic [wbum_pkg::REG_W-1:0] window_length_ns;

  // Per-request working registers.
  logic [TW-1:0]    now_r;
  logic             busy_r;
  logic [TW-1:0]    elapsed;
  logic [TW:0]      lhs;
  logic             young;
  logic [TW-1:0]    last_update_time;
  logic [TW-1:0]    busy_time_sum;
  logic             prev_busy;
  logic             rise_r;
  logic             fall_r;
  logic [CNT_W-1:0] ring_count;
  logic [SLOT_W-1:0] sum_idx;
  logic [TW-1:0]    sum_total;
  logic [TW-1:0]    sum_active;
  logic [wbum_pkg::UTIL_W-1:0] util_r;

  // Cell chain.
  wbum_pkg::bucket_t  cell_data [SLOTS];
  wbum_pkg::bucket_t  cell_prev [SLOTS];
  wbum_pkg::bucket_t  cell_next [SLOTS];
  wbum_pkg::cell_op_t cell_op   [SLOTS];
  wbum_pkg::cell_op_t chain_op;
  wbum_pkg::cell_op_t head_op;
  wbum_pkg::bucket_t  new_bucket;
  wbum_pkg::bucket_t  merged_bucket;

  logic [TW-1:0]    active_amt;
  logic [TW:0]      span;
  logic [SLOT_W-1:0] oldest_idx;
  wbum_pkg::bucket_t oldest;
  logic [TW:0]      age;
  logic             expired;
  logic             sum_take;

  // Divider hookup.
  logic                        div_start;
  logic [TW-1:0]               div_a;
  logic [wbum_pkg::UTIL_W-1:0] div_q;
  logic                        div_done;

  assign in_ready = (state == S_IDLE) && !result_wait;

  // The elapsed time is only credited as busy when the flag is set.
  assign active_amt = busy_r ? elapsed : '0;

  assign new_bucket.end_ns = now_r;
  assign new_bucket.sum_ns = elapsed;
  assign new_bucket.act_ns = active_amt;

  assign merged_bucket.end_ns = now_r;
  assign merged_bucket.sum_ns = wbum_pkg::sat_add(cell_data[0].sum_ns, elapsed);
  assign merged_bucket.act_ns = wbum_pkg::sat_add(cell_data[0].act_ns, active_amt);

  // Span of the newest bucket is (now + total) - end. When now + total lies
  // below the end, the bucket starts after now, which counts as young.
  assign span = lhs - {1'b0, cell_data[0].end_ns};

  // The oldest live bucket sits in the highest occupied cell.
  assign oldest_idx = SLOT_W'(ring_count - CNT_W'(1));
  assign oldest     = cell_data[oldest_idx];
  assign age        = {1'b0, now_r} - {1'b0, oldest.end_ns};
  assign expired    = !age[TW] && (age[TW-1:0] > {{(TW-wbum_pkg::REG_W){1'b0}},
                                                 window_length_ns});

  assign sum_take = CNT_W'(sum_idx) < ring_count;

  // Chain operation: push on a new bucket or merge into cell 0, rotate while summing.
  always_comb begin
    chain_op = wbum_pkg::CELL_HOLD;
    head_op  = wbum_pkg::CELL_HOLD;
    if (state == S_UPD) begin
      if (young) begin
        head_op = wbum_pkg::CELL_WRITE;
      end else begin
        chain_op = wbum_pkg::CELL_UP;
        head_op  = wbum_pkg::CELL_UP;
      end
    end else if (state == S_SUM) begin
      chain_op = wbum_pkg::CELL_DOWN;
      head_op  = wbum_pkg::CELL_DOWN;
    end
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_prev[i] = new_bucket;
      assign cell_op[i]   = head_op;
    end else begin : g_body
      assign cell_prev[i] = cell_data[i-1];
      assign cell_op[i]   = chain_op;
    end
    if (i == SLOTS - 1) begin : g_tail
      assign cell_next[i] = cell_data[0];
    end else begin : g_link
      assign cell_next[i] = cell_data[i+1];
    end

    wbum_cell u_cell (
      .clk     (clk),
      .op      (cell_op[i]),
      .prev_in (cell_prev[i]),
      .next_in (cell_next[i]),
      .wr_in   (merged_bucket),
      .data    (cell_data[i])
    );
  end

  // Busy time can only exceed total time through clipping; bound it.
  assign div_a     = (sum_active > sum_total) ? sum_total : sum_active;
  assign div_start = (state == S_CHK) && (sum_total != '0);

  wbum_divider u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (div_a),
    .t     (sum_total),
    .q     (div_q),
    .done  (div_done)
  );

  // Configuration writes land whenever they come.
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_length_ns <= wbum_pkg::BUCKET_LENGTH_RESET;
      window_length_ns <= wbum_pkg::WINDOW_LENGTH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wbum_pkg::REG_BUCKET_LENGTH: bucket_length_ns <= cfg_data;
        wbum_pkg::REG_WINDOW_LENGTH: window_length_ns <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: state, working registers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      result_wait      <= 1'b0;
      out_valid        <= 1'b0;
      ring_count       <= '0;
      last_update_time <= '0;
      busy_time_sum    <= '0;
      prev_busy        <= 1'b0;
    end else begin
      // A finished result moves to the output register once it is free.
      if (result_wait && (!out_valid || out_ready)) begin
        result_wait        <= 1'b0;
        out_valid          <= 1'b1;
        utilization_q7_8   <= util_r;
        busy_time_total_ns <= busy_time_sum;
        busy_state         <= busy_r;
        became_busy        <= rise_r;
        became_idle        <= fall_r;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            now_r  <= timestamp_ns;
            busy_r <= busy_now;
            state  <= S_PREP;
          end
        end
        S_PREP: begin
          // A timestamp that goes backwards credits no time.
          elapsed <= (now_r >= last_update_time) ? now_r - last_update_time : '0;
          lhs     <= {1'b0, now_r} + {1'b0, cell_data[0].sum_ns};
          state   <= S_YOUNG;
        end
        S_YOUNG: begin
          young <= (ring_count != '0) &&
                   ((lhs < {1'b0, cell_data[0].end_ns}) ||
                    (span < {{(TW+1-wbum_pkg::REG_W){1'b0}}, bucket_length_ns}));
          state <= S_UPD;
        end
        S_UPD: begin
          if (busy_r) begin
            busy_time_sum <= wbum_pkg::sat_add(busy_time_sum, elapsed);
          end
          // When the ring is full the push drops the oldest cell.
          if (!young && (ring_count != CNT_W'(SLOTS))) begin
            ring_count <= ring_count + CNT_W'(1);
          end
          rise_r           <= !prev_busy && busy_r;
          fall_r           <= prev_busy && !busy_r;
          prev_busy        <= busy_r;
          last_update_time <= now_r;
          state            <= S_EXP;
        end
        S_EXP: begin
          if ((ring_count != '0) && expired) begin
            ring_count <= ring_count - CNT_W'(1);
          end else begin
            sum_idx    <= '0;
            sum_total  <= '0;
            sum_active <= '0;
            state      <= S_SUM;
          end
        end
        S_SUM: begin
          // After a full turn the chain is back in its original order.
          if (sum_take) begin
            sum_total  <= wbum_pkg::sat_add(sum_total, cell_data[0].sum_ns);
            sum_active <= wbum_pkg::sat_add(sum_active, cell_data[0].act_ns);
          end
          sum_idx <= sum_idx + SLOT_W'(1);
          if (sum_idx == SLOT_W'(SLOTS - 1)) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (sum_total == '0) begin
            util_r      <= '0;
            result_wait <= 1'b1;
            state       <= S_IDLE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            util_r      <= div_q;
            result_wait <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The ring never holds more buckets than it has cells.
  assert property (@(posedge clk) disable iff (rst) ring_count <= CNT_W'(SLOTS))
    else $error("ring count above slot count");

  // The newest bucket always ends at now, so expiry never empties the ring.
  assert property (@(posedge clk) disable iff (rst) (state == S_SUM) |-> (ring_count != '0))
    else $error("ring empty during summing pass");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst) div_done |-> (state == S_DIV))
    else $error("divider finished outside divide state");

  // Utilization never exceeds one hundred percent.
  assert property (@(posedge clk) disable iff (rst)
                   out_valid |-> (utilization_q7_8 <= wbum_pkg::FULL_SCALE))
    else $error("utilization above full scale");

  // An accepted request always starts its work at the next cycle.
  assert property (@(posedge clk) disable iff (rst)
                   (in_valid && in_ready) |=> (state == S_PREP))
    else $error("accepted request did not start");

endmodule

FILE: sv/wbum_cell.sv
// One bucket of the ring. Cell 0 holds the newest bucket; a new bucket
// pushes every entry one cell up, and a summing pass rotates them down.
module wbum_cell (
  input  logic               clk,
  input  wbum_pkg::cell_op_t op,
  input  wbum_pkg::bucket_t  prev_in,
  input  wbum_pkg::bucket_t  next_in,
  input  wbum_pkg::bucket_t  wr_in,
  output wbum_pkg::bucket_t  data
);

  always_ff @(posedge clk) begin
    unique case (op)
      wbum_pkg::CELL_HOLD:  data <= data;
      wbum_pkg::CELL_UP:    data <= prev_in;
      wbum_pkg::CELL_DOWN:  data <= next_in;
      wbum_pkg::CELL_WRITE: data <= wr_in;
      default:              data <= data;
    endcase
  end

endmodule

FILE: sv/wbum_divider.sv
// Serial unit for floor(a * FULL_SCALE / t), a <= t, t > 0. Each bit of the
// scale takes a shift step, then an add step that adds only where it is set.
module wbum_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wbum_pkg::TIME_W-1:0]   a,
  input  logic [wbum_pkg::TIME_W-1:0]   t,
  output logic [wbum_pkg::UTIL_W-1:0]   q,
  output logic                          done
);

  localparam int BIT_W = $clog2(wbum_pkg::UTIL_W);

  logic                          run;
  logic                          phase;
  logic [BIT_W-1:0]              bit_idx;
  logic [wbum_pkg::TIME_W:0]     r;
  logic [wbum_pkg::TIME_W-1:0]   a_reg;
  logic [wbum_pkg::TIME_W-1:0]   t_reg;

  logic [wbum_pkg::TIME_W:0] r_shift;
  logic [wbum_pkg::TIME_W:0] r_add;
  logic                      shift_ge;
  logic                      add_ge;

  // The remainder stays below t, so neither step overflows 64 bits.
  assign r_shift  = {r[wbum_pkg::TIME_W-1:0], 1'b0};
  assign r_add    = r + {1'b0, a_reg};
  assign shift_ge = r_shift >= {1'b0, t_reg};
  assign add_ge   = r_add >= {1'b0, t_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run     <= 1'b1;
        phase   <= 1'b0;
        bit_idx <= BIT_W'(wbum_pkg::UTIL_W - 1);
        r       <= '0;
        q       <= '0;
        a_reg   <= a;
        t_reg   <= t;
      end else if (run) begin
        if (!phase) begin
          r     <= shift_ge ? r_shift - {1'b0, t_reg} : r_shift;
          q     <= {q[wbum_pkg::UTIL_W-2:0], shift_ge};
          phase <= 1'b1;
        end else begin
          if (wbum_pkg::FULL_SCALE[bit_idx]) begin
            r <= add_ge ? r_add - {1'b0, t_reg} : r_add;
            q <= q + wbum_pkg::UTIL_W'(add_ge);
          end
          phase <= 1'b0;
          if (bit_idx == '0) begin
            run  <= 1'b0;
            done <= 1'b1;
          end else begin
            bit_idx <= bit_idx - BIT_W'(1);
          end
        end
      end
    end
  end

endmodule

FILE: tb/tb_windowed_busy_utilization_meter_top.sv
`timescale 1ns / 1ps

module tb_windowed_busy_utilization_meter_top;

  // The run is bounded so that a hung handshake cannot stall it forever.
  localparam int CYCLE_LIMIT  = 1000000;
  // Cycles the receiver refuses results during the back-pressure phase.
  localparam int HOLD_CYCLES  = 400;
  // Cycles allowed after the last expected result for stray results to show up.
  localparam int DRAIN_CYCLES = 200;
  localparam int DIRECTED_COUNT = 19;
  localparam int PLAN_COUNT = 6;

  localparam logic [wbum_pkg::REG_W-1:0] REG_MAX = {wbum_pkg::REG_W{1'b1}};

  // One result as the block presents it.
  typedef struct packed {
    logic [wbum_pkg::UTIL_W-1:0] util;
    logic [wbum_pkg::TIME_W-1:0] busy_total;
    logic                        busy;
    logic                        rise;
    logic                        fall;
  } meter_reading_t;

  // One directed request, with its result typed in where it is obvious.
  typedef struct packed {
    logic [wbum_pkg::TIME_W-1:0] stamp;
    logic                        busy;
    logic                        known;
    meter_reading_t              reading;
  } probe_row_t;

  // Register settings and handshake behavior of one random phase.
  typedef struct {
    logic [wbum_pkg::REG_W-1:0] span_ns;
    logic [wbum_pkg::REG_W-1:0] window;
    int                         send_idle_pct;
    int                         recv_stall_pct;
    int                         items;
    bit                         squeeze;
  } plan_t;

  // The first four rows start from reset with the default register values, so their results
  // can be worked out by hand. The rest walk through backwards time, negative bucket spans,
  // buckets that end after the current time, saturation of the busy total and of the ring
  // sums, and alternating bit patterns of the timestamp.
  localparam probe_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{63'd0,          1'b0, 1'b1, '{15'd0,     63'd0,    1'b0, 1'b0, 1'b0}},
    '{63'd1000,       1'b1, 1'b1, '{15'd25600, 63'd1000, 1'b1, 1'b1, 1'b0}},
    '{63'd2000,       1'b0, 1'b1, '{15'd12800, 63'd1000, 1'b0, 1'b0, 1'b1}},
    '{63'd1500,       1'b1, 1'b1, '{15'd12800, 63'd1000, 1'b1, 1'b1, 1'b0}},
    '{63'd1000001500, 1'b1, 1'b0, '0},
    '{63'd1000001400, 1'b0, 1'b0, '0},
    '{63'd500,        1'b1, 1'b0, '0},
    '{63'd20000000000, 1'b0, 1'b0, '0},
    '{63'd20000000100, 1'b1, 1'b0, '0},
    '{63'd19000000000, 1'b0, 1'b0, '0},
    '{wbum_pkg::TIME_MAX, 1'b1, 1'b0, '0},
    '{63'd0,          1'b1, 1'b0, '0},
    '{wbum_pkg::TIME_MAX, 1'b1, 1'b0, '0},
    '{wbum_pkg::TIME_MAX - 63'd5000000000, 1'b1, 1'b0, '0},
    '{wbum_pkg::TIME_MAX - 63'd3000000000, 1'b1, 1'b0, '0},
    '{63'd1,          1'b0, 1'b0, '0},
    '{wbum_pkg::TIME_MAX, 1'b1, 1'b0, '0},
    '{63'h5555_5555_5555_5555, 1'b0, 1'b0, '0},
    '{63'h2AAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, '0}
  };

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [wbum_pkg::TIME_W-1:0]    timestamp_ns = '0;
  logic                           busy_now = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [wbum_pkg::UTIL_W-1:0]    utilization_q7_8;
  logic [wbum_pkg::TIME_W-1:0]    busy_time_total_ns;
  logic                           busy_state;
  logic                           became_busy;
  logic                           became_idle;
  logic                           cfg_write = 1'b0;
  logic [wbum_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [wbum_pkg::REG_W-1:0]     cfg_data = '0;

  windowed_busy_utilization_meter_top u_top (.*);

  always #1 clk = ~clk;

  // Results still owed by the block, oldest first, and the hand-worked answers of the
  // directed rows, one entry per directed request in the order they are offered.
  meter_reading_t expected_readings [$];
  probe_row_t     directed_answers [$];
  int             mismatch_count = 0;
  int             cycle_count = 0;

  // Receiver behavior, set by the stimulus process with nonblocking writes. Each increment
  // of hold_req asks the receiver for one long hold-off.
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Mirror of the meter: register values, the ring of time buckets and the running totals.
  logic [wbum_pkg::REG_W-1:0]  span_limit_ns = wbum_pkg::BUCKET_LENGTH_RESET;
  logic [wbum_pkg::REG_W-1:0]  window_ns = wbum_pkg::WINDOW_LENGTH_RESET;
  logic [wbum_pkg::TIME_W-1:0] last_seen_ns = '0;
  logic [wbum_pkg::TIME_W-1:0] busy_accum_ns = '0;
  logic                        last_busy = 1'b0;
  logic [wbum_pkg::TIME_W-1:0] slot_end_ns   [wbum_pkg::BUCKET_SLOTS];
  logic [wbum_pkg::TIME_W-1:0] slot_total_ns [wbum_pkg::BUCKET_SLOTS];
  logic [wbum_pkg::TIME_W-1:0] slot_busy_ns  [wbum_pkg::BUCKET_SLOTS];
  int                          oldest_slot = 0;
  int                          live_slots = 0;

  // Adds two times and clips the sum at the largest 63-bit value.
  function automatic logic [wbum_pkg::TIME_W-1:0] clip_add(
      input logic [wbum_pkg::TIME_W-1:0] a, input logic [wbum_pkg::TIME_W-1:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, wbum_pkg::TIME_MAX})
      return wbum_pkg::TIME_MAX;
    return s[wbum_pkg::TIME_W-1:0];
  endfunction

  // Applies one update to the mirrored meter and returns the reading it must produce.
  function automatic meter_reading_t predict_reading(input logic [wbum_pkg::TIME_W-1:0] now,
                                                     input logic busy);
    meter_reading_t              r;
    logic [wbum_pkg::TIME_W-1:0] gap_ns;
    logic [wbum_pkg::TIME_W-1:0] busy_ns;
    logic [wbum_pkg::TIME_W-1:0] tot_sum;
    logic [wbum_pkg::TIME_W-1:0] act_sum;
    logic [63:0]                 reach;
    logic [127:0]                scaled;
    int                          slot;
    bit                          merged;

    // Time running backwards credits nothing.
    gap_ns = (now >= last_seen_ns) ? now - last_seen_ns : '0;
    busy_ns = busy ? gap_ns : '0;
    if (busy)
      busy_accum_ns = clip_add(busy_accum_ns, gap_ns);

    // The newest bucket absorbs the update while its span, start to now, is short enough.
    // A start that lies after now is a negative span and always absorbs.
    merged = 1'b0;
    if (live_slots > 0) begin
      slot = (oldest_slot + live_slots - 1) % wbum_pkg::BUCKET_SLOTS;
      reach = {1'b0, now} + {1'b0, slot_total_ns[slot]};
      if (reach < {1'b0, slot_end_ns[slot]} ||
          reach - {1'b0, slot_end_ns[slot]} < {24'd0, span_limit_ns}) begin
        merged = 1'b1;
        slot_end_ns[slot] = now;
        slot_total_ns[slot] = clip_add(slot_total_ns[slot], gap_ns);
        slot_busy_ns[slot] = clip_add(slot_busy_ns[slot], busy_ns);
      end
    end

    // Otherwise a fresh bucket opens, pushing out the oldest when the ring is full.
    if (!merged) begin
      if (live_slots >= wbum_pkg::BUCKET_SLOTS) begin
        oldest_slot = (oldest_slot + 1) % wbum_pkg::BUCKET_SLOTS;
        live_slots = wbum_pkg::BUCKET_SLOTS - 1;
      end
      slot = (oldest_slot + live_slots) % wbum_pkg::BUCKET_SLOTS;
      slot_end_ns[slot] = now;
      slot_total_ns[slot] = gap_ns;
      slot_busy_ns[slot] = busy_ns;
      live_slots++;
    end

    // Expiry stops at the first bucket that is still inside the window.
    while (live_slots > 0 && now > slot_end_ns[oldest_slot] &&
           now - slot_end_ns[oldest_slot] > {23'd0, window_ns}) begin
      oldest_slot = (oldest_slot + 1) % wbum_pkg::BUCKET_SLOTS;
      live_slots--;
    end

    tot_sum = '0;
    act_sum = '0;
    for (int k = 0; k < live_slots; k++) begin
      slot = (oldest_slot + k) % wbum_pkg::BUCKET_SLOTS;
      tot_sum = clip_add(tot_sum, slot_total_ns[slot]);
      act_sum = clip_add(act_sum, slot_busy_ns[slot]);
    end

    r.util = '0;
    if (tot_sum != '0) begin
      if (act_sum > tot_sum)
        act_sum = tot_sum;
      scaled = ({65'd0, act_sum} * {113'd0, wbum_pkg::FULL_SCALE}) / {65'd0, tot_sum};
      r.util = scaled[wbum_pkg::UTIL_W-1:0];
    end
    r.busy_total = busy_accum_ns;
    r.busy = busy;
    r.rise = !last_busy && busy;
    r.fall = last_busy && !busy;

    last_seen_ns = now;
    last_busy = busy;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Everything is observed at the rising edge, where the values seen are the ones the block
  // itself samples. Register writes update the mirror, accepted requests are run through the
  // predictor, and each accepted result is compared with the oldest reading still owed.
  // Results are checked before the new request is queued so that a stray result can never
  // be matched against a request taken at the same edge.
  always @(posedge clk) begin : watch
    meter_reading_t want;
    probe_row_t     row;
    if (!rst) begin
      if (cfg_write) begin
        case (cfg_index)
          wbum_pkg::REG_BUCKET_LENGTH: span_limit_ns = cfg_data;
          wbum_pkg::REG_WINDOW_LENGTH: window_ns = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result arrived with no request outstanding", $time);
        end else begin
          want = expected_readings[0];
          expected_readings.delete(0);
          check_field("utilization_q7_8", 64'(want.util), 64'(utilization_q7_8));
          check_field("busy_time_total_ns", 64'(want.busy_total), 64'(busy_time_total_ns));
          check_field("busy_state", 64'(want.busy), 64'(busy_state));
          check_field("became_busy", 64'(want.rise), 64'(became_busy));
          check_field("became_idle", 64'(want.fall), 64'(became_idle));
        end
      end
      if (in_valid && in_ready) begin
        want = predict_reading(timestamp_ns, busy_now);
        if (directed_answers.size() > 0) begin
          row = directed_answers[0];
          directed_answers.delete(0);
          if (row.known)
            want = row.reading;
        end
        expected_readings.push_back(want);
      end
    end
  end

  // The receiver either takes every result, refuses a random share of cycles, or, when asked,
  // refuses everything for a long stretch so that the block backs up into its input.
  always @(posedge clk) begin : downstream
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Gap before the next request. Most gaps are short runs of idle cycles; now and then a long
  // one lets the block finish and sit idle, so that requests land on every stage of its work.
  function automatic int sender_gap(input int idle_pct);
    int g;
    g = 0;
    if (idle_pct == 0)
      return 0;
    if ($urandom_range(7) == 0)
      return $urandom_range(90, 1);
    while ($urandom_range(99) < idle_pct)
      g++;
    return g;
  endfunction

  // Next timestamp, shaped by the register values: mostly small steps that merge into the
  // newest bucket, a good share that open a new one, some that reach across the window, and
  // a few backward steps and fully random times.
  function automatic logic [wbum_pkg::TIME_W-1:0] next_stamp(
      input logic [wbum_pkg::TIME_W-1:0] cur, input logic [wbum_pkg::REG_W-1:0] span,
      input logic [wbum_pkg::REG_W-1:0] window);
    int unsigned roll;
    logic [63:0] raw;
    logic [63:0] advance;
    logic [63:0] span64;
    logic [63:0] window64;
    raw = rand64();
    roll = $urandom_range(99);
    span64 = {24'd0, span};
    window64 = {24'd0, window};
    if (roll < 6)
      return raw[wbum_pkg::TIME_W-1:0];
    if (roll < 12) begin
      advance = raw % (span64 + 2);
      return cur - advance[wbum_pkg::TIME_W-1:0];
    end
    if (roll < 60)
      advance = raw % (span64 / 2 + 2);
    else if (roll < 88)
      advance = span64 + raw % (span64 + 2);
    else
      advance = raw % (window64 + window64 / 4 + 2);
    return cur + advance[wbum_pkg::TIME_W-1:0];
  endfunction

  // Offers one request and returns at the edge that accepts it. Valid is only lowered when
  // a gap is wanted, so it is never dropped and raised again within one step.
  task automatic offer_request(input logic [wbum_pkg::TIME_W-1:0] stamp, input logic busy,
                               input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    timestamp_ns <= stamp;
    busy_now <= busy;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_for_results();
    while (expected_readings.size() != 0)
      @(posedge clk);
  endtask

  initial begin : stimulus
    plan_t                       plans [PLAN_COUNT];
    logic [wbum_pkg::TIME_W-1:0] cur_ns;
    logic                        cur_busy;
    logic [63:0]                 raw;

    // Extremes of both registers, a ring that fills and wraps, zero lengths, random values,
    // and short buckets with a short window so that expiry is constant.
    plans[0] = '{40'd1, 40'd1, 69, 0, 120, 1'b0};
    plans[1] = '{REG_MAX, REG_MAX, 0, 69, 120, 1'b0};
    plans[2] = '{40'd1000, 40'd100000, 30, 30, 140, 1'b0};
    plans[3] = '{40'd0, 40'd0, 0, 0, 130, 1'b1};
    raw = rand64();
    plans[4].span_ns = raw[wbum_pkg::REG_W-1:0] >> $urandom_range(wbum_pkg::REG_W-1);
    raw = rand64();
    plans[4].window = raw[wbum_pkg::REG_W-1:0] >> $urandom_range(wbum_pkg::REG_W-1);
    plans[4].send_idle_pct = 69;
    plans[4].recv_stall_pct = 0;
    plans[4].items = 120;
    plans[4].squeeze = 1'b0;
    plans[5] = '{40'd50, 40'd600, 0, 69, 120, 1'b0};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, back to back, under the reset register values.
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      directed_answers.push_back(DIRECTED_ROWS[i]);
      offer_request(DIRECTED_ROWS[i].stamp, DIRECTED_ROWS[i].busy, 0);
    end
    in_valid <= 1'b0;
    cur_ns = DIRECTED_ROWS[DIRECTED_COUNT-1].stamp;
    cur_busy = DIRECTED_ROWS[DIRECTED_COUNT-1].busy;

    for (int p = 0; p < PLAN_COUNT; p++) begin
      // Registers change only once the block has handed over every result.
      wait_for_results();
      cfg_write <= 1'b1;
      cfg_index <= wbum_pkg::REG_BUCKET_LENGTH;
      cfg_data <= plans[p].span_ns;
      @(posedge clk);
      cfg_index <= wbum_pkg::REG_WINDOW_LENGTH;
      cfg_data <= plans[p].window;
      @(posedge clk);
      cfg_write <= 1'b0;
      recv_stall_pct <= plans[p].recv_stall_pct;
      if (plans[p].squeeze)
        hold_req <= hold_req + 1;

      for (int n = 0; n < plans[p].items; n++) begin
        cur_ns = next_stamp(cur_ns, plans[p].span_ns, plans[p].window);
        if ($urandom_range(99) < 35)
          cur_busy = ~cur_busy;
        offer_request(cur_ns, cur_busy, sender_gap(plans[p].send_idle_pct));
      end
      in_valid <= 1'b0;
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
